FILE: hdl/grsp_pkg.sv
// ----------------------------------------------------------------------------
// grsp_pkg
// Shared types and constants for the randomized greedy path search unit.
// ----------------------------------------------------------------------------
package grsp_pkg;

  localparam int NODES       = 8;
  localparam int NODE_BITS   = 3;
  localparam int ADDR_BITS   = 2 * NODE_BITS;
  localparam int WEIGHT_BITS = 16;
  localparam int TOTAL_BITS  = 24;
  localparam int ALPHA_BITS  = 9;
  localparam int CNT_BITS    = 20;
  localparam int STEP_BITS   = 8;
  localparam int LFSR_BITS   = 32;

  localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 32'h8020_0003;

  // Register reset values.
  localparam logic [CNT_BITS-1:0]   ATTEMPT_RST = 20'd1000000;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RST   = 9'd154;
  localparam logic [LFSR_BITS-1:0]  SEED_RST    = 32'd1;
  localparam logic [STEP_BITS-1:0]  LIMIT_RST   = 8'd64;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ATTEMPT = 2'd0;
  localparam logic [1:0] REG_ALPHA   = 2'd1;
  localparam logic [1:0] REG_SEED    = 2'd2;
  localparam logic [1:0] REG_LIMIT   = 2'd3;

  // Input item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration seen by the sequencer.
  typedef struct packed {
    logic [CNT_BITS-1:0]   attempt_count;
    logic [ALPHA_BITS-1:0] alpha_q8;
    logic [STEP_BITS-1:0]  step_limit;
    logic                  seed_wr;
    logic [LFSR_BITS-1:0]  seed;
  } cfg_t;

endpackage

FILE: hdl/grasp_greedy_random_path_search_unit.sv
// ----------------------------------------------------------------------------
// grasp_greedy_random_path_search_unit
// Randomized greedy walks over an 8-node weighted directed graph.
// ----------------------------------------------------------------------------
// A load transaction writes one edge weight and gives no result; loads are
// taken back to back. A query transaction runs attempt_count walks and
// returns one result. Each walk step reads the eight weights of the current
// node from the weight memory, forms the candidate threshold with one
// multiply, qualifies the candidates, reduces the LFSR modulo the candidate
// count eight bits a cycle, ranks neighbors one per cycle on a shared
// comparator bank and makes the move. A step with no neighbors ends the walk
// after the scan. The block accepts nothing else while a query runs.
// ----------------------------------------------------------------------------
module grasp_greedy_random_path_search_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_kind,
  input  logic [grsp_pkg::NODE_BITS-1:0]        in_from_node,
  input  logic [grsp_pkg::NODE_BITS-1:0]        in_to_node,
  input  logic [grsp_pkg::WEIGHT_BITS-1:0]      in_weight,
  input  logic [grsp_pkg::NODE_BITS-1:0]        in_start_node,
  input  logic [grsp_pkg::NODE_BITS-1:0]        in_end_node,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [grsp_pkg::TOTAL_BITS-1:0]       out_best_total,
  output logic                                  out_path_found,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCAN    = 9'b000000010,
    S_THR     = 9'b000000100,
    S_CAND    = 9'b000001000,
    S_MOD     = 9'b000010000,
    S_PICK    = 9'b000100000,
    S_MOVE    = 9'b001000000,
    S_WALKEND = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  localparam int NB = grsp_pkg::NODE_BITS;
  localparam int WB = grsp_pkg::WEIGHT_BITS;
  localparam int TB = grsp_pkg::TOTAL_BITS;
  localparam int PB = WB + grsp_pkg::ALPHA_BITS;

  grsp_pkg::cfg_t cfg;

  state_t                 state_r;
  logic [NB-1:0]          start_r, end_r, cur_r, pick_r, cap_idx_r, pick_i_r;
  logic [NB:0]            scan_idx_r;
  logic                   cap_vld_r;
  logic [WB-1:0]          rowbuf_r [grsp_pkg::NODES];
  logic [WB-1:0]          lo_r, hi_r;
  logic [NB:0]            n_r, cnt_r, rem_r;
  logic [PB-1:0]          prod_r;
  logic [grsp_pkg::NODES-1:0] cand_r;
  logic [1:0]             mod_k_r;
  logic [TB-1:0]          total_r, best_r;
  logic                   found_r, ok_r;
  logic [grsp_pkg::CNT_BITS-1:0]  attempt_r;
  logic [grsp_pkg::STEP_BITS-1:0] step_r;
  logic [grsp_pkg::LFSR_BITS-1:0] lfsr_r;
  logic                   out_valid_r;
  logic [TB-1:0]          out_best_r;
  logic                   out_found_r;

  logic                   in_acc, load_wr;
  logic [WB-1:0]          rd_data;
  logic [grsp_pkg::ADDR_BITS-1:0] rd_addr;
  logic [PB:0]            thr_off;
  logic [WB+1:0]          thr;
  logic [grsp_pkg::NODES-1:0] cand_nxt;
  logic [NB:0]            cnt_nxt, rem_nxt, rank;
  logic                   pick_hit;
  logic [TB:0]            sum;
  logic [grsp_pkg::LFSR_BITS-1:0] lfsr_nxt;
  logic [7:0]             mod_byte;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_wr   = in_acc && (in_kind == grsp_pkg::KIND_LOAD);
  assign rd_addr   = {cur_r, scan_idx_r[NB-1:0]};

  grsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  grsp_wstore u_wstore (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_wr),
    .wr_addr ({in_from_node, in_to_node}),
    .wr_data (in_weight),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Threshold, candidate mask and candidate count.
  always_comb begin
    thr_off = (PB+1)'({1'b0, prod_r} + (PB+1)'(128)) >> 8;
    thr     = (WB+2)'(lo_r) + (WB+2)'(thr_off);
    cnt_nxt = '0;
    for (int i = 0; i < grsp_pkg::NODES; i++) begin
      cand_nxt[i] = (rowbuf_r[i] != '0) && ((WB+2)'(rowbuf_r[i]) <= thr);
      cnt_nxt     = cnt_nxt + (NB+1)'(cand_nxt[i]);
    end
  end

  // Remainder unit: eight bits of the LFSR a cycle, most significant first.
  always_comb begin
    mod_byte = lfsr_r[{~mod_k_r, 3'b000} +: 8];
    rem_nxt  = rem_r;
    for (int b = 7; b >= 0; b--) begin
      rem_nxt = {rem_nxt[NB-1:0], mod_byte[b]};
      if (rem_nxt >= cnt_r) begin
        rem_nxt = rem_nxt - cnt_r;
      end
    end
  end

  // Rank of neighbor pick_i_r in weight order, ties to the lower index.
  always_comb begin
    rank = '0;
    for (int j = 0; j < grsp_pkg::NODES; j++) begin
      if (cand_r[j] && ((rowbuf_r[j] < rowbuf_r[pick_i_r]) ||
          ((rowbuf_r[j] == rowbuf_r[pick_i_r]) && (NB'(j) < pick_i_r)))) begin
        rank = rank + 1'b1;
      end
    end
    pick_hit = cand_r[pick_i_r] && (rank == rem_r);
  end

  // Saturating walk total and next LFSR value.
  always_comb begin
    sum      = (TB+1)'(total_r) + (TB+1)'(rowbuf_r[pick_r]);
    lfsr_nxt = lfsr_r >> 1;
    if (lfsr_r[0]) begin
      lfsr_nxt = lfsr_nxt ^ grsp_pkg::LFSR_TAPS;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lfsr_r      <= grsp_pkg::SEED_RST;
      best_r      <= '1;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cap_vld_r   <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      // The done state refills the output register itself.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg.seed_wr) begin
        lfsr_r <= (cfg.seed != '0) ? cfg.seed : grsp_pkg::SEED_RST;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_kind == grsp_pkg::KIND_QUERY)) begin
            best_r     <= '1;
            found_r    <= 1'b0;
            attempt_r  <= '0;
            cur_r      <= in_start_node;
            start_r    <= in_start_node;
            end_r      <= in_end_node;
            total_r    <= '0;
            step_r     <= '0;
            scan_idx_r <= '0;
            cap_vld_r  <= 1'b0;
            n_r        <= '0;
            state_r    <= (cfg.attempt_count == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue one read a cycle; the registered read data is captured through cap_vld_r and cap_idx_r.
          if (!scan_idx_r[NB]) begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
          cap_vld_r <= !scan_idx_r[NB];
          cap_idx_r <= scan_idx_r[NB-1:0];
          if (cap_vld_r) begin
            rowbuf_r[cap_idx_r] <= rd_data;
            if (rd_data != '0) begin
              n_r  <= n_r + 1'b1;
              lo_r <= (n_r == '0 || rd_data < lo_r) ? rd_data : lo_r;
              hi_r <= (n_r == '0 || rd_data > hi_r) ? rd_data : hi_r;
            end
            if (cap_idx_r == NB'(grsp_pkg::NODES - 1)) begin
              state_r <= S_THR;
            end
          end
        end
        S_THR: begin
          if (n_r == '0) begin
            ok_r    <= (cur_r == end_r);
            state_r <= S_WALKEND;
          end else begin
            prod_r  <= PB'(hi_r - lo_r) * PB'(cfg.alpha_q8);
            state_r <= S_CAND;
          end
        end
        S_CAND: begin
          cand_r  <= cand_nxt;
          cnt_r   <= cnt_nxt;
          lfsr_r  <= lfsr_nxt;
          rem_r   <= '0;
          mod_k_r <= '0;
          state_r <= S_MOD;
        end
        S_MOD: begin
          rem_r   <= rem_nxt;
          mod_k_r <= mod_k_r + 1'b1;
          if (mod_k_r == 2'd3) begin
            pick_i_r <= '0;
            state_r  <= S_PICK;
          end
        end
        S_PICK: begin
          if (pick_hit) begin
            pick_r  <= pick_i_r;
            state_r <= S_MOVE;
          end else begin
            pick_i_r <= pick_i_r + 1'b1;
          end
        end
        S_MOVE: begin
          total_r    <= sum[TB] ? '1 : sum[TB-1:0];
          cur_r      <= pick_r;
          step_r     <= step_r + 1'b1;
          scan_idx_r <= '0;
          cap_vld_r  <= 1'b0;
          n_r        <= '0;
          if (pick_r == end_r) begin
            ok_r    <= 1'b1;
            state_r <= S_WALKEND;
          end else if ((step_r + 1'b1) >= cfg.step_limit) begin
            ok_r    <= 1'b0;
            state_r <= S_WALKEND;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_WALKEND: begin
          if (ok_r) begin
            found_r <= 1'b1;
            if (total_r < best_r) begin
              best_r <= total_r;
            end
          end
          attempt_r  <= attempt_r + 1'b1;
          cur_r      <= start_r;
          total_r    <= '0;
          step_r     <= '0;
          scan_idx_r <= '0;
          cap_vld_r  <= 1'b0;
          n_r        <= '0;
          state_r    <= ((attempt_r + 1'b1) == cfg.attempt_count) ? S_DONE : S_SCAN;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_best_r  <= best_r;
            out_found_r <= found_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_total = out_best_r;
  assign out_path_found = out_found_r;

  // The remainder unit only runs with at least one candidate.
  a_mod_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> (cnt_r != '0))
    else $error("remainder unit running with no candidates");

  // The chosen rank always lies within the candidate list.
  a_rem_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> (rem_r < cnt_r))
    else $error("pick rank beyond candidate count");

  // The rank search finds its candidate by the last neighbor.
  a_pick_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK && pick_i_r == NB'(grsp_pkg::NODES - 1)) |-> pick_hit)
    else $error("rank search ran past the last neighbor");

  // Without a successful walk the best total stays all ones.
  a_best_none: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> (best_r == '1))
    else $error("best total changed without a successful walk");

endmodule

FILE: hdl/grsp_wstore.sv
// ----------------------------------------------------------------------------
// grsp_wstore
// Edge weight memory, one write and one registered read per cycle. Valid bits
// make every entry read as zero until it is first written.
// ----------------------------------------------------------------------------
module grsp_wstore (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [grsp_pkg::ADDR_BITS-1:0]       wr_addr,
  input  logic [grsp_pkg::WEIGHT_BITS-1:0]     wr_data,
  input  logic [grsp_pkg::ADDR_BITS-1:0]       rd_addr,
  output logic [grsp_pkg::WEIGHT_BITS-1:0]     rd_data
);

  logic [grsp_pkg::WEIGHT_BITS-1:0] mem [grsp_pkg::NODES*grsp_pkg::NODES];
  logic [grsp_pkg::NODES*grsp_pkg::NODES-1:0] vld_r;
  logic [grsp_pkg::WEIGHT_BITS-1:0] mem_q_r;
  logic                             vld_q_r;

  // Valid bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Memory array with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
    vld_q_r <= vld_r[rd_addr];
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

FILE: hdl/grsp_cfg.sv
// ----------------------------------------------------------------------------
// grsp_cfg
// APB-style register file holding the search configuration.
// ----------------------------------------------------------------------------
module grsp_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output grsp_pkg::cfg_t      cfg
);

  logic [grsp_pkg::CNT_BITS-1:0]   attempt_r;
  logic [grsp_pkg::ALPHA_BITS-1:0] alpha_r;
  logic [grsp_pkg::LFSR_BITS-1:0]  seed_r;
  logic [grsp_pkg::STEP_BITS-1:0]  limit_r;
  logic                            wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempt_r <= grsp_pkg::ATTEMPT_RST;
      alpha_r   <= grsp_pkg::ALPHA_RST;
      seed_r    <= grsp_pkg::SEED_RST;
      limit_r   <= grsp_pkg::LIMIT_RST;
    end else if (wr) begin
      case (paddr[3:2])
        grsp_pkg::REG_ATTEMPT: attempt_r <= pwdata[grsp_pkg::CNT_BITS-1:0];
        grsp_pkg::REG_ALPHA:   alpha_r   <= pwdata[grsp_pkg::ALPHA_BITS-1:0];
        grsp_pkg::REG_SEED:    seed_r    <= pwdata;
        grsp_pkg::REG_LIMIT:   limit_r   <= pwdata[grsp_pkg::STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      grsp_pkg::REG_ATTEMPT: prdata = 32'(attempt_r);
      grsp_pkg::REG_ALPHA:   prdata = 32'(alpha_r);
      grsp_pkg::REG_SEED:    prdata = seed_r;
      grsp_pkg::REG_LIMIT:   prdata = 32'(limit_r);
      default:               prdata = '0;
    endcase
  end

  // Configuration outputs; the seed write also reloads the random generator.
  always_comb begin
    cfg.attempt_count = attempt_r;
    cfg.alpha_q8      = alpha_r;
    cfg.step_limit    = limit_r;
    cfg.seed_wr       = wr && (paddr[3:2] == grsp_pkg::REG_SEED);
    cfg.seed          = pwdata;
  end

endmodule

FILE: verif/tb_grasp_greedy_random_path_search_unit.sv
// ----------------------------------------------------------------------------
// tb_grasp_greedy_random_path_search_unit
// Self-checking testbench for the randomized greedy path search unit.
// ----------------------------------------------------------------------------
// Edge loads and route queries are driven on the input channel. A local model
// of the graph, the LFSR and the walk rules predicts every query result, and
// a monitor compares each result transaction with the oldest prediction.
// Directed cases cover the corner behavior. Random traffic follows under
// changing register settings and changing idle patterns on both channels,
// and one long receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
module tb_grasp_greedy_random_path_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 1500;

  typedef struct packed {
    logic [grsp_pkg::TOTAL_BITS-1:0] best_total;
    logic                            path_found;
  } route_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             in_kind = grsp_pkg::KIND_LOAD;
  logic [grsp_pkg::NODE_BITS-1:0]   in_from_node = '0;
  logic [grsp_pkg::NODE_BITS-1:0]   in_to_node = '0;
  logic [grsp_pkg::WEIGHT_BITS-1:0] in_weight = '0;
  logic [grsp_pkg::NODE_BITS-1:0]   in_start_node = '0;
  logic [grsp_pkg::NODE_BITS-1:0]   in_end_node = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [grsp_pkg::TOTAL_BITS-1:0]  out_best_total;
  logic                             out_path_found;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [3:0]                       paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  // Model state.
  logic [grsp_pkg::WEIGHT_BITS-1:0] graph_w [0:grsp_pkg::NODES*grsp_pkg::NODES-1];
  logic [grsp_pkg::LFSR_BITS-1:0]   lfsr_q;
  logic [grsp_pkg::CNT_BITS-1:0]    walks_per_query;
  logic [grsp_pkg::ALPHA_BITS-1:0]  alpha_cfg;
  logic [grsp_pkg::STEP_BITS-1:0]   move_limit;

  route_result_t route_expect_q[$];
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  logic          hold_active = 1'b0;
  event          hold_ev;
  int unsigned   cycle_count = 0;
  int unsigned   error_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   results_seen = 0;

  grasp_greedy_random_path_search_unit dut (.*);

  // Clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grasp_greedy_random_path_search_unit: mismatch");
      $finish;
    end
  end

  // Hold-off window, counted in clock cycles once requested.
  always begin
    @(hold_ev);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Receiver: random ready, or held low during a hold-off window.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_active) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    route_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (route_expect_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result total=%0d found=%0b", $time,
                 out_best_total, out_path_found);
      end else begin
        exp_r = route_expect_q.pop_front();
        if (exp_r.best_total !== out_best_total) begin
          error_count++;
          $display("%0t: best_total expected %0d actual %0d", $time,
                   exp_r.best_total, out_best_total);
        end
        if (exp_r.path_found !== out_path_found) begin
          error_count++;
          $display("%0t: path_found expected %0b actual %0b", $time,
                   exp_r.path_found, out_path_found);
        end
      end
    end
  end

  // Advance the Galois LFSR once and return the new value.
  function automatic logic [grsp_pkg::LFSR_BITS-1:0] lfsr_advance();
    logic lsb;
    lsb = lfsr_q[0];
    lfsr_q = lfsr_q >> 1;
    if (lsb) lfsr_q = lfsr_q ^ grsp_pkg::LFSR_TAPS;
    return lfsr_q;
  endfunction

  // One greedy move from node cur; returns the neighbor count.
  function automatic int unsigned greedy_move(ref logic [grsp_pkg::NODE_BITS-1:0] cur,
                                              ref logic [grsp_pkg::TOTAL_BITS-1:0] sum);
    int unsigned n;
    int unsigned cnt;
    int unsigned j;
    logic [grsp_pkg::WEIGHT_BITS-1:0] w;
    logic [grsp_pkg::WEIGHT_BITS-1:0] lo;
    logic [grsp_pkg::WEIGHT_BITS-1:0] hi;
    logic [63:0] thr;
    logic [grsp_pkg::NODE_BITS-1:0] ranked [0:grsp_pkg::NODES-1];
    logic [grsp_pkg::NODE_BITS-1:0] pick;
    logic [grsp_pkg::TOTAL_BITS:0] wide_sum;
    n = 0;
    cnt = 0;
    lo = '0;
    hi = '0;
    for (int i = 0; i < grsp_pkg::NODES; i++) begin
      w = graph_w[cur*grsp_pkg::NODES+i];
      if (w != 0) begin
        if (n == 0 || w < lo) lo = w;
        if (n == 0 || w > hi) hi = w;
        n++;
      end
    end
    if (n == 0) return 0;
    thr = 64'(lo) + ((64'(hi - lo) * 64'(alpha_cfg) + 64'd128) >> 8);
    // Stable insertion keeps equal weights in index order.
    for (int i = 0; i < grsp_pkg::NODES; i++) begin
      w = graph_w[cur*grsp_pkg::NODES+i];
      if (w != 0 && 64'(w) <= thr) begin
        j = cnt;
        while (j > 0 && graph_w[cur*grsp_pkg::NODES+ranked[j-1]] > w) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = grsp_pkg::NODE_BITS'(i);
        cnt++;
      end
    end
    pick = ranked[lfsr_advance() % cnt];
    wide_sum = {1'b0, sum} +
               (grsp_pkg::TOTAL_BITS+1)'(graph_w[cur*grsp_pkg::NODES+pick]);
    sum = wide_sum[grsp_pkg::TOTAL_BITS] ? '1 : wide_sum[grsp_pkg::TOTAL_BITS-1:0];
    cur = pick;
    return n;
  endfunction

  // Full query: all walks from start, best successful total.
  function automatic route_result_t route_query(logic [grsp_pkg::NODE_BITS-1:0] start,
                                                logic [grsp_pkg::NODE_BITS-1:0] goal);
    route_result_t r;
    logic [grsp_pkg::NODE_BITS-1:0] cur;
    logic [grsp_pkg::TOTAL_BITS-1:0] sum;
    logic [grsp_pkg::STEP_BITS-1:0] moves;
    int unsigned n;
    r.best_total = '1;
    r.path_found = 1'b0;
    for (int unsigned a = 0; a < walks_per_query; a++) begin
      cur = start;
      sum = '0;
      moves = '0;
      forever begin
        n = greedy_move(cur, sum);
        if (n != 0) moves = moves + 1'b1;
        if (cur == goal) begin
          r.path_found = 1'b1;
          if (sum < r.best_total) r.best_total = sum;
          break;
        end
        if (n == 0 || moves >= move_limit) break;
      end
    end
    return r;
  endfunction

  // Offer one transaction and hold it until accepted, then apply it to the model.
  task automatic send_item(logic kind, logic [2:0] f, logic [2:0] t,
                           logic [15:0] w, logic [2:0] s, logic [2:0] e);
    int unsigned gap;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_from_node <= f;
    in_to_node <= t;
    in_weight <= w;
    in_start_node <= s;
    in_end_node <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (kind == grsp_pkg::KIND_LOAD) graph_w[{f, t}] = w;
    else route_expect_q = {route_expect_q, route_query(s, e)};
    // Decide the gap before the next transaction at the acceptance edge.
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(logic [2:0] f, logic [2:0] t, logic [15:0] w);
    send_item(grsp_pkg::KIND_LOAD, f, t, w, 3'($urandom), 3'($urandom));
  endtask

  task automatic send_query(logic [2:0] s, logic [2:0] e);
    send_item(grsp_pkg::KIND_QUERY, 3'($urandom), 3'($urandom), 16'($urandom), s, e);
  endtask

  // Stop offering and wait until every result has arrived and the block settles.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (route_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      grsp_pkg::REG_ATTEMPT: walks_per_query = val[grsp_pkg::CNT_BITS-1:0];
      grsp_pkg::REG_ALPHA:   alpha_cfg = val[grsp_pkg::ALPHA_BITS-1:0];
      grsp_pkg::REG_SEED:    lfsr_q = (val == 32'd0) ? grsp_pkg::SEED_RST : val;
      grsp_pkg::REG_LIMIT:   move_limit = val[grsp_pkg::STEP_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [31:0] walks, logic [31:0] alpha, logic [31:0] seed,
                         logic [31:0] lim);
    cfg_write(grsp_pkg::REG_ATTEMPT, walks);
    cfg_write(grsp_pkg::REG_ALPHA, alpha);
    cfg_write(grsp_pkg::REG_SEED, seed);
    cfg_write(grsp_pkg::REG_LIMIT, lim);
  endtask

  // Directed corner cases.
  task automatic test_directed();
    cfg_all(32'd4, 32'd154, 32'h0000_ACE1, 32'd8);
    send_query(3'd0, 3'd0);
    send_query(3'd0, 3'd5);
    send_load(3'd0, 3'd1, 16'd5);
    send_load(3'd1, 3'd2, 16'd7);
    send_load(3'd2, 3'd0, 16'd3);
    send_load(3'd0, 3'd3, 16'hFFFF);
    send_load(3'd3, 3'd2, 16'd1);
    send_load(3'd7, 3'd7, 16'hFFFF);
    send_query(3'd0, 3'd2);
    send_query(3'd0, 3'd0);
    send_query(3'd7, 3'd7);
    send_load(3'd7, 3'd7, 16'd0);
    send_query(3'd7, 3'd7);
    send_query(3'd2, 3'd6);
    drain();
    cfg_write(grsp_pkg::REG_LIMIT, 32'd0);
    send_query(3'd0, 3'd2);
    drain();
    cfg_write(grsp_pkg::REG_ATTEMPT, 32'd0);
    send_query(3'd0, 3'd2);
    drain();
    cfg_all(32'd3, 32'd0, 32'd0, 32'd6);
    send_query(3'd0, 3'd2);
    drain();
    cfg_all(32'd3, 32'd511, 32'hFFFF_FFFF, 32'd6);
    send_query(3'd0, 3'd2);
    drain();
    cfg_all(32'd2, 32'd256, 32'h1234_5678, 32'd255);
    send_query(3'd0, 3'd6);
    drain();
  endtask

  // Random mix of loads and queries under one idle pattern.
  task automatic test_random_phase(int unsigned s_pct, int unsigned r_pct,
                                   int unsigned count);
    logic [15:0] w;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % (count / 2) == 0) begin
        drain();
        cfg_all($urandom_range(1, 4),
                ($urandom_range(9) == 0) ? 32'd511 : $urandom_range(0, 256),
                $urandom, $urandom_range(1, 12));
      end
      if ($urandom_range(99) < 65) begin
        case ($urandom_range(3))
          0: w = 16'h0000;
          1: w = 16'($urandom_range(1, 15));
          2: w = 16'($urandom);
          default: w = 16'hFFFF;
        endcase
        send_load(3'($urandom), 3'($urandom), w);
      end else begin
        send_query(3'($urandom), 3'($urandom));
      end
    end
    drain();
  endtask

  // Long receiver hold-off while queries keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_all(32'd2, 32'd154, $urandom, 32'd6);
    @(negedge clk);
    -> hold_ev;
    @(posedge clk);
    for (int i = 0; i < 8; i++) send_query(3'($urandom), 3'($urandom));
    drain();
  endtask

  initial begin
    for (int i = 0; i < grsp_pkg::NODES*grsp_pkg::NODES; i++) graph_w[i] = '0;
    lfsr_q = grsp_pkg::SEED_RST;
    walks_per_query = grsp_pkg::ATTEMPT_RST;
    alpha_cfg = grsp_pkg::ALPHA_RST;
    move_limit = grsp_pkg::LIMIT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(37, 72, 560);
    test_random_phase(72, 37, 560);
    test_backpressure();
    test_random_phase(0, 0, 560);
    $display("Covered %0d transactions sent, %0d results checked, %0d errors.",
             items_sent, results_seen, error_count);
    $display("Settings swept walk counts, alpha extremes, seeds and step limits.");
    if (error_count == 0 && route_expect_q.size() == 0) begin
      $display("grasp_greedy_random_path_search_unit: match");
    end else begin
      $display("grasp_greedy_random_path_search_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: grasp_greedy_random_path_search_unit.f
hdl/grsp_pkg.sv
hdl/grsp_wstore.sv
hdl/grsp_cfg.sv
hdl/grasp_greedy_random_path_search_unit.sv
verif/tb_grasp_greedy_random_path_search_unit.sv
